[src/olr_pkg.sv]
// shared types, constants and helpers for the online prefix regression block
package olr_pkg;

  localparam logic signed [63:0] ONE_Q32    = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] LN2_Q32    = 64'sd2977044472;
  localparam logic signed [63:0] TWO_PI_Q32 = 64'sd26986075409;
  localparam logic signed [63:0] S64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN    = 64'sh8000_0000_0000_0000;

  localparam logic [5:0] SH_Q20  = 6'd20;
  localparam logic [5:0] SH_Q32  = 6'd32;
  localparam logic [5:0] SH_HALF = 6'd1;
  localparam logic [5:0] SH_NONE = 6'd0;

  localparam logic [0:0] CFG_MIN_CLUSTER = 1'b0;
  localparam logic [0:0] CFG_SERIES_LEN  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_XVAR  = 2'd1;
  localparam logic [1:0] STAT_RESID = 2'd2;

  typedef enum logic [1:0] {
    MD_MUL   = 2'd0,
    MD_SHIFT = 2'd1,
    MD_DIV   = 2'd2
  } md_mode_t;

  typedef struct packed {
    logic               start;
    md_mode_t           mode;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [63:0]        d;
    logic [5:0]         shamt;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] q;
    logic [127:0]       prod;
  } md_resp_t;

  typedef struct packed {
    logic               valid;
    logic signed [63:0] slope;
    logic signed [63:0] intercept;
    logic [62:0]        residual_variance;
    logic [32:0]        r_squared;
    logic signed [63:0] log_likelihood;
    logic [15:0]        prefix_count;
    logic [1:0]         status;
    logic               last_result;
  } olr_res_t;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

endpackage

[src/online_prefix_linear_regression_top.sv]
// top level: configuration registers, input handshake and result register
//
// Takes one (x, y) sample per input transaction (valid/ready) and returns at
// most one fit result per sample on the output channel (valid/ready).
// A result is produced once the prefix holds min_cluster samples and while
// at least min_cluster samples of the series remain; the accumulators clear
// after the last sample of a series.
// in_ready is high only while the sequencer is idle. A sample takes longer
// when the fit runs than when it yields no result or a zero x variance
// result, and longest when it also gets a log-likelihood: each divide runs
// 128 restoring steps in the one shared multiply/divide unit, and each of
// the two logarithms needs a normalize loop plus 32 squarings through the
// same unit.
// Results sit in an output register; the next sample is accepted while a
// result waits, and the sequencer holds its finished result until the
// output register is free, so a stalled receiver only stalls the block.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// are meant for idle periods. Synchronous reset restores min_cluster 10,
// series_length 1024 and clears all accumulators.
module online_prefix_linear_regression_top #(
  parameter int MAX_SERIES = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample_x,
  input  logic signed [31:0] in_sample_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_slope,
  output logic signed [63:0] out_intercept,
  output logic [62:0]        out_residual_variance,
  output logic [32:0]        out_r_squared,
  output logic signed [63:0] out_log_likelihood,
  output logic [15:0]        out_prefix_count,
  output logic [1:0]         out_status,
  output logic               out_last_result,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import olr_pkg::*;

  logic [14:0] mc_r;
  logic [15:0] len_r, len_eff;
  logic        out_valid_r, out_free, idle;
  olr_res_t    res, res_r;

  assign len_eff = (len_r == 16'd0) ? 16'd1 :
                   (len_r > 16'(MAX_SERIES)) ? 16'(MAX_SERIES) : len_r;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = idle;

  olr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_valid && idle),
    .sample_x     (in_sample_x),
    .sample_y     (in_sample_y),
    .min_cluster  (mc_r),
    .series_length(len_eff),
    .out_free     (out_free),
    .idle         (idle),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r        <= 15'd10;
      len_r       <= 16'd1024;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_CLUSTER: mc_r  <= cfg_wdata[14:0];
          CFG_SERIES_LEN:  len_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (res.valid) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) res_r <= res;
  end

  assign out_valid             = out_valid_r;
  assign out_slope             = res_r.slope;
  assign out_intercept         = res_r.intercept;
  assign out_residual_variance = res_r.residual_variance;
  assign out_r_squared         = res_r.r_squared;
  assign out_log_likelihood    = res_r.log_likelihood;
  assign out_prefix_count      = res_r.prefix_count;
  assign out_status            = res_r.status;
  assign out_last_result       = res_r.last_result;

endmodule

[src/olr_muldiv.sv]
// shared multiply, shift and restoring divide unit: saturated a*b, a*b >> shamt or trunc(a*b/d)
module olr_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  olr_pkg::md_req_t  req,
  output olr_pkg::md_resp_t resp
);
  import olr_pkg::*;

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_SHF  = 5'b00100,
    U_DIV  = 5'b01000,
    U_FIN  = 5'b10000
  } ustate_t;

  ustate_t            state_r, state_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [63:0]        am_r, am_nxt, bm_r, bm_nxt, d_r, d_nxt, rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  md_mode_t           mode_r, mode_nxt;
  logic [5:0]         sh_r, sh_nxt;
  logic [127:0]       prod_r, prod_nxt;
  logic signed [63:0] q_r, q_nxt;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] ppw;
  logic [64:0]  rsh;
  logic [65:0]  rdif;
  logic [63:0]  lim, qm;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    am_nxt    = am_r;
    bm_nxt    = bm_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    mode_nxt  = mode_r;
    sh_nxt    = sh_r;
    prod_nxt  = prod_r;
    q_nxt     = q_r;

    pa = idx_r[0] ? am_r[63:32] : am_r[31:0];
    pb = idx_r[1] ? bm_r[63:32] : bm_r[31:0];
    pp = 64'(pa) * 64'(pb);
    case (idx_r)
      2'd0:    ppw = {64'd0, pp};
      2'd3:    ppw = {pp, 64'd0};
      default: ppw = {32'd0, pp, 32'd0};
    endcase

    rsh  = {rem_r, prod_r[127]};
    rdif = {1'b0, rsh} - {2'b00, d_r};
    lim  = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    qm   = (prod_r[127:64] != 64'd0 || prod_r[63:0] > lim) ? lim : prod_r[63:0];

    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          am_nxt    = mag(req.a);
          bm_nxt    = mag(req.b);
          neg_nxt   = req.a[63] ^ req.b[63];
          mode_nxt  = req.mode;
          d_nxt     = req.d;
          sh_nxt    = req.shamt;
          idx_nxt   = 2'd0;
          prod_nxt  = 128'd0;
          state_nxt = U_MUL;
        end
      end
      U_MUL: begin
        prod_nxt = prod_r + ppw;
        idx_nxt  = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          case (mode_r)
            MD_SHIFT: state_nxt = U_SHF;
            MD_DIV: begin
              rem_nxt   = 64'd0;
              cnt_nxt   = 7'd0;
              state_nxt = U_DIV;
            end
            default:  state_nxt = U_FIN;
          endcase
        end
      end
      U_SHF: begin
        prod_nxt  = prod_r >> sh_r;
        state_nxt = U_FIN;
      end
      U_DIV: begin
        rem_nxt  = rdif[65] ? rsh[63:0] : rdif[63:0];
        prod_nxt = {prod_r[126:0], ~rdif[65]};
        cnt_nxt  = cnt_r + 7'd1;
        if (cnt_r == 7'd127) state_nxt = U_FIN;
      end
      U_FIN: begin
        if (mode_r == MD_DIV && d_r == 64'd0) q_nxt = 64'sd0;
        else q_nxt = neg_r ? $signed(64'd0 - qm) : $signed(qm);
        done_nxt  = 1'b1;
        state_nxt = U_IDLE;
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    am_r   <= am_nxt;
    bm_r   <= bm_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    mode_r <= mode_nxt;
    sh_r   <= sh_nxt;
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
  end

  assign resp.done = done_r;
  assign resp.q    = q_r;
  assign resp.prod = prod_r;

endmodule

[src/olr_core.sv]
// sequencer and accumulators: welford update, line fit and log-likelihood
module olr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  sample_x,
  input  logic signed [31:0]  sample_y,
  input  logic [14:0]         min_cluster,
  input  logic [15:0]         series_length,
  input  logic                out_free,
  output logic                idle,
  output olr_pkg::olr_res_t   res
);
  import olr_pkg::*;

  typedef enum logic [4:0] {
    C_IDLE  = 5'b00001,
    C_ISSUE = 5'b00010,
    C_WAIT  = 5'b00100,
    C_NORM  = 5'b01000,
    C_DONE  = 5'b10000
  } cstate_t;

  typedef enum logic [3:0] {
    ST_MX, ST_MY, ST_SX, ST_SY, ST_P, ST_PN, ST_SLOPE, ST_MY12, ST_SM,
    ST_EXPL, ST_VAR, ST_RSQ, ST_LNSQ, ST_LNSC, ST_LL
  } step_t;

  cstate_t            st_r, st_nxt;
  step_t              step_r, step_nxt;
  logic [16:0]        n_r, n_nxt;
  logic [15:0]        count_r, count_nxt;
  logic signed [63:0] mean_x_r, mean_x_nxt, mean_y_r, mean_y_nxt;
  logic signed [63:0] ssx_r, ssx_nxt, ssy_r, ssy_nxt, com_r, com_nxt;
  logic signed [63:0] x_r, x_nxt, y_r, y_nxt, dxp_r, dxp_nxt, dyp_r, dyp_nxt;
  logic signed [63:0] p_r, p_nxt, slope_r, slope_nxt, tmp_r, tmp_nxt;
  logic signed [63:0] icpt_r, icpt_nxt, expl_r, expl_nxt, resid_r, resid_nxt;
  logic signed [63:0] var_r, var_nxt, ll_r, ll_nxt, term_r, term_nxt;
  logic [32:0]        rsq_r, rsq_nxt;
  logic [63:0]        z_r, z_nxt;
  logic [5:0]         msb_r, msb_nxt;
  logic [31:0]        frac_r, frac_nxt;
  logic [4:0]         it_r, it_nxt;
  logic               lnv_r, lnv_nxt, emit_r, emit_nxt, last_r, last_nxt;
  logic               clr_r, clr_nxt;
  logic [1:0]         status_r, status_nxt;

  md_req_t            md_req;
  md_resp_t           md_resp;

  logic signed [63:0] wx, wy, q;
  logic [63:0]        zs;
  logic [17:0]        nmc;
  logic [14:0]        mc;
  logic signed [31:0] ie;

  olr_muldiv u_md (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (md_req),
    .resp (md_resp)
  );

  assign mc  = (min_cluster == 15'd0) ? 15'd1 : min_cluster;
  assign nmc = {1'b0, n_r} + {3'b000, mc};
  assign wx  = {{28{sample_x[31]}}, sample_x, 4'b0000};
  assign wy  = {{28{sample_y[31]}}, sample_y, 4'b0000};
  assign q   = md_resp.q;
  assign zs  = md_resp.prod[125:62];
  assign ie  = 32'($signed({1'b0, msb_r})) - 32'sd32;

  always_comb begin
    md_req.start = (st_r == C_ISSUE);
    md_req.mode  = MD_DIV;
    md_req.a     = dxp_r;
    md_req.b     = 64'sd1;
    md_req.d     = 64'(n_r);
    md_req.shamt = SH_NONE;
    case (step_r)
      ST_MX: ;
      ST_MY: md_req.a = dyp_r;
      ST_SX: begin
        md_req.mode = MD_SHIFT; md_req.b = x_r - mean_x_r; md_req.shamt = SH_Q20;
      end
      ST_SY: begin
        md_req.mode = MD_SHIFT; md_req.a = dyp_r; md_req.b = y_r - mean_y_r;
        md_req.shamt = SH_Q20;
      end
      ST_P: begin
        md_req.mode = MD_SHIFT; md_req.b = dyp_r; md_req.shamt = SH_Q20;
      end
      ST_PN: md_req.a = p_r;
      ST_SLOPE: begin
        md_req.a = com_r; md_req.b = ONE_Q32; md_req.d = 64'(ssx_r);
      end
      ST_MY12: begin
        md_req.mode = MD_SHIFT; md_req.a = mean_y_r; md_req.b = 64'sd4096;
      end
      ST_SM: begin
        md_req.mode = MD_SHIFT; md_req.a = slope_r; md_req.b = mean_x_r;
        md_req.shamt = SH_Q20;
      end
      ST_EXPL: begin
        md_req.a = com_r; md_req.b = com_r; md_req.d = 64'(ssx_r);
      end
      ST_VAR: begin
        md_req.a = resid_r; md_req.b = 64'sd4096;
      end
      ST_RSQ: begin
        md_req.a = expl_r; md_req.b = ONE_Q32; md_req.d = 64'(ssy_r);
      end
      ST_LNSQ: begin
        md_req.mode = MD_MUL; md_req.a = $signed(z_r); md_req.b = $signed(z_r);
      end
      ST_LNSC: begin
        md_req.mode = MD_SHIFT; md_req.a = $signed({ie, frac_r}); md_req.b = LN2_Q32;
        md_req.shamt = SH_Q32;
      end
      ST_LL: begin
        md_req.mode = MD_SHIFT; md_req.a = $signed(64'd0 - 64'(n_r));
        md_req.b = term_r; md_req.shamt = SH_HALF;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    step_nxt   = step_r;
    n_nxt      = n_r;
    count_nxt  = count_r;
    mean_x_nxt = mean_x_r;
    mean_y_nxt = mean_y_r;
    ssx_nxt    = ssx_r;
    ssy_nxt    = ssy_r;
    com_nxt    = com_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dxp_nxt    = dxp_r;
    dyp_nxt    = dyp_r;
    p_nxt      = p_r;
    slope_nxt  = slope_r;
    tmp_nxt    = tmp_r;
    icpt_nxt   = icpt_r;
    expl_nxt   = expl_r;
    resid_nxt  = resid_r;
    var_nxt    = var_r;
    ll_nxt     = ll_r;
    term_nxt   = term_r;
    rsq_nxt    = rsq_r;
    z_nxt      = z_r;
    msb_nxt    = msb_r;
    frac_nxt   = frac_r;
    it_nxt     = it_r;
    lnv_nxt    = lnv_r;
    emit_nxt   = emit_r;
    last_nxt   = last_r;
    clr_nxt    = clr_r;
    status_nxt = status_r;

    case (st_r)
      C_IDLE: begin
        if (start) begin
          x_nxt    = wx;
          y_nxt    = wy;
          dxp_nxt  = wx - mean_x_r;
          dyp_nxt  = wy - mean_y_r;
          n_nxt    = {1'b0, count_r} + 17'd1;
          step_nxt = ST_MX;
          st_nxt   = C_ISSUE;
        end
      end
      C_ISSUE: st_nxt = C_WAIT;
      C_NORM: begin
        if (z_r[62]) begin
          it_nxt   = 5'd31;
          frac_nxt = 32'd0;
          step_nxt = ST_LNSQ;
          st_nxt   = C_ISSUE;
        end else begin
          z_nxt   = {z_r[62:0], 1'b0};
          msb_nxt = msb_r - 6'd1;
        end
      end
      C_WAIT: begin
        if (md_resp.done) begin
          st_nxt = C_ISSUE;
          case (step_r)
            ST_MX: begin mean_x_nxt = mean_x_r + q; step_nxt = ST_MY; end
            ST_MY: begin mean_y_nxt = mean_y_r + q; step_nxt = ST_SX; end
            ST_SX: begin ssx_nxt = sat_add(ssx_r, q); step_nxt = ST_SY; end
            ST_SY: begin ssy_nxt = sat_add(ssy_r, q); step_nxt = ST_P; end
            ST_P:  begin p_nxt = q; step_nxt = ST_PN; end
            ST_PN: begin
              com_nxt    = sat_add(com_r, p_r - q);
              count_nxt  = n_r[15:0];
              emit_nxt   = (n_r >= {2'b00, mc}) && (nmc <= {2'b00, series_length});
              last_nxt   = (nmc == {2'b00, series_length});
              clr_nxt    = (n_r >= {1'b0, series_length});
              slope_nxt  = 64'sd0;
              icpt_nxt   = 64'sd0;
              var_nxt    = 64'sd0;
              rsq_nxt    = 33'd0;
              ll_nxt     = 64'sd0;
              status_nxt = STAT_OK;
              step_nxt   = ST_SLOPE;
              if (!((n_r >= {2'b00, mc}) && (nmc <= {2'b00, series_length}))) begin
                st_nxt = C_DONE;
              end else if (ssx_r <= 64'sd0) begin
                status_nxt = STAT_XVAR;
                st_nxt     = C_DONE;
              end
            end
            ST_SLOPE: begin slope_nxt = q; step_nxt = ST_MY12; end
            ST_MY12:  begin tmp_nxt = q; step_nxt = ST_SM; end
            ST_SM:    begin icpt_nxt = sat_sub(tmp_r, q); step_nxt = ST_EXPL; end
            ST_EXPL: begin
              expl_nxt  = q;
              resid_nxt = sat_sub(ssy_r, q);
              step_nxt  = ST_VAR;
            end
            ST_VAR: begin
              var_nxt  = (resid_r > 64'sd0) ? q : 64'sd0;
              step_nxt = ST_RSQ;
            end
            ST_RSQ: begin
              if (ssy_r <= 64'sd0) rsq_nxt = 33'd0;
              else if (q < 64'sd0) rsq_nxt = 33'd0;
              else if (q > ONE_Q32) rsq_nxt = ONE_Q32[32:0];
              else rsq_nxt = q[32:0];
              if (var_r <= 64'sd0 || ssy_r <= 64'sd0) begin
                status_nxt = STAT_RESID;
                st_nxt     = C_DONE;
              end else begin
                z_nxt   = 64'(TWO_PI_Q32);
                msb_nxt = 6'd62;
                lnv_nxt = 1'b0;
                st_nxt  = C_NORM;
              end
            end
            ST_LNSQ: begin
              if (zs[63]) begin
                frac_nxt[it_r] = 1'b1;
                z_nxt          = {1'b0, zs[63:1]};
              end else begin
                z_nxt = zs;
              end
              it_nxt = it_r - 5'd1;
              if (it_r == 5'd0) step_nxt = ST_LNSC;
            end
            ST_LNSC: begin
              if (!lnv_r) begin
                term_nxt = ONE_Q32 + q;
                z_nxt    = 64'(var_r);
                msb_nxt  = 6'd62;
                lnv_nxt  = 1'b1;
                st_nxt   = C_NORM;
              end else begin
                term_nxt = term_r + q;
                step_nxt = ST_LL;
              end
            end
            ST_LL: begin ll_nxt = q; st_nxt = C_DONE; end
            default: st_nxt = C_IDLE;
          endcase
        end
      end
      C_DONE: begin
        if (!emit_r || out_free) begin
          if (clr_r) begin
            count_nxt  = 16'd0;
            mean_x_nxt = 64'sd0;
            mean_y_nxt = 64'sd0;
            ssx_nxt    = 64'sd0;
            ssy_nxt    = 64'sd0;
            com_nxt    = 64'sd0;
          end
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= C_IDLE;
      step_r   <= ST_MX;
      count_r  <= 16'd0;
      mean_x_r <= 64'sd0;
      mean_y_r <= 64'sd0;
      ssx_r    <= 64'sd0;
      ssy_r    <= 64'sd0;
      com_r    <= 64'sd0;
    end else begin
      st_r     <= st_nxt;
      step_r   <= step_nxt;
      count_r  <= count_nxt;
      mean_x_r <= mean_x_nxt;
      mean_y_r <= mean_y_nxt;
      ssx_r    <= ssx_nxt;
      ssy_r    <= ssy_nxt;
      com_r    <= com_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    dxp_r    <= dxp_nxt;
    dyp_r    <= dyp_nxt;
    p_r      <= p_nxt;
    slope_r  <= slope_nxt;
    tmp_r    <= tmp_nxt;
    icpt_r   <= icpt_nxt;
    expl_r   <= expl_nxt;
    resid_r  <= resid_nxt;
    var_r    <= var_nxt;
    ll_r     <= ll_nxt;
    term_r   <= term_nxt;
    rsq_r    <= rsq_nxt;
    z_r      <= z_nxt;
    msb_r    <= msb_nxt;
    frac_r   <= frac_nxt;
    it_r     <= it_nxt;
    lnv_r    <= lnv_nxt;
    emit_r   <= emit_nxt;
    last_r   <= last_nxt;
    clr_r    <= clr_nxt;
    status_r <= status_nxt;
  end

  assign idle                  = (st_r == C_IDLE);
  assign res.valid             = (st_r == C_DONE) && emit_r && out_free;
  assign res.slope             = slope_r;
  assign res.intercept         = icpt_r;
  assign res.residual_variance = var_r[62:0];
  assign res.r_squared         = rsq_r;
  assign res.log_likelihood    = ll_r;
  assign res.prefix_count      = n_r[15:0];
  assign res.status            = status_r;
  assign res.last_result       = last_r;

endmodule

[dv/online_prefix_linear_regression_top_tb.sv]
// testbench for the online prefix linear regression block
`timescale 1ns / 1ps

module online_prefix_linear_regression_top_tb;
  import olr_pkg::*;

  localparam int unsigned SERIES_CAP = 65535;
  localparam int unsigned SETTLE_CYCLES = 2500;
  localparam longint unsigned CYCLE_LIMIT = 8_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_sample_x;
  logic signed [31:0] in_sample_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] out_slope;
  logic signed [63:0] out_intercept;
  logic [62:0]        out_residual_variance;
  logic [32:0]        out_r_squared;
  logic signed [63:0] out_log_likelihood;
  logic [15:0]        out_prefix_count;
  logic [1:0]         out_status;
  logic               out_last_result;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [15:0]        cfg_wdata;

  online_prefix_linear_regression_top i_dut (.*);

  // predictor state
  int unsigned        min_cluster_reg;
  int unsigned        series_len_reg;
  int unsigned        sample_cnt;
  logic signed [63:0] mean_x, mean_y, sumsq_x, sumsq_y, comoment;
  olr_res_t           fit_q[$];

  int     error_count;
  int     samples_sent;
  int     fits_checked;
  int     status_seen[3];
  int     burst_left;
  longint unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? 64'sh8000_0000_0000_0000 :
                                                     64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? 64'sh8000_0000_0000_0000 :
                                                     64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  // trunc(a*b/d) saturated, zero for a zero divisor
  function automatic logic signed [63:0] scaled_quot(logic signed [63:0] a,
                                                     logic signed [63:0] b,
                                                     logic [63:0] d);
    logic [127:0] ma, mb, q;
    logic         neg;
    logic [63:0]  lim;
    if (d == 0) return 0;
    neg = a[63] ^ b[63];
    ma = {64'd0, a[63] ? 64'd0 - a : a};
    mb = {64'd0, b[63] ? 64'd0 - b : b};
    q = (ma * mb) / {64'd0, d};
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (q > {64'd0, lim}) q = {64'd0, lim};
    return neg ? 64'd0 - q[63:0] : q[63:0];
  endfunction

  function automatic logic signed [63:0] ln_fixed(logic [63:0] v);
    int           msb;
    logic [63:0]  z;
    logic [127:0] sq;
    logic [63:0]  frac;
    longint       ip;
    msb = 63;
    frac = 0;
    while (msb > 0 && !v[msb]) msb--;
    z = (msb > 62) ? v >> 1 : v << (62 - msb);
    for (int i = 31; i >= 0; i--) begin
      sq = {64'd0, z} * {64'd0, z};
      z = sq[125:62];
      if (z[63]) begin
        frac[i] = 1'b1;
        z = z >> 1;
      end
    end
    ip = longint'(msb - 32) * ONE_Q32 + longint'(frac);
    return scaled_quot(ip, LN2_Q32, ONE_Q32);
  endfunction

  task automatic clear_fit_state();
    sample_cnt = 0;
    mean_x = 0; mean_y = 0; sumsq_x = 0; sumsq_y = 0; comoment = 0;
  endtask

  task automatic predict_fit(logic signed [31:0] sx, logic signed [31:0] sy);
    logic signed [63:0] x, y, dx, dy, p, expl, resid, term;
    int unsigned        mc, len, n;
    olr_res_t           r;
    x = 64'(sx) <<< 4;
    y = 64'(sy) <<< 4;
    mc = (min_cluster_reg == 0) ? 1 : min_cluster_reg;
    len = (series_len_reg == 0) ? 1 : series_len_reg;
    if (len > SERIES_CAP) len = SERIES_CAP;
    n = sample_cnt + 1;
    dx = x - mean_x;
    dy = y - mean_y;
    mean_x = mean_x + dx / longint'(n);
    mean_y = mean_y + dy / longint'(n);
    sumsq_x = sadd(sumsq_x, scaled_quot(dx, x - mean_x, 64'd1048576));
    sumsq_y = sadd(sumsq_y, scaled_quot(dy, y - mean_y, 64'd1048576));
    p = scaled_quot(dx, dy, 64'd1048576);
    comoment = sadd(comoment, p - p / longint'(n));
    sample_cnt = n & 16'hFFFF;
    if (n >= mc && n + mc <= len) begin
      r = '0;
      r.valid = 1'b1;
      r.status = STAT_OK;
      if (sumsq_x <= 0) begin
        r.status = STAT_XVAR;
      end else begin
        logic signed [63:0] slope, var_v, rsq;
        slope = scaled_quot(comoment, ONE_Q32, sumsq_x);
        r.slope = slope;
        r.intercept = ssub(scaled_quot(mean_y, 64'sd4096, 64'd1),
                           scaled_quot(slope, mean_x, 64'd1048576));
        expl = scaled_quot(comoment, comoment, sumsq_x);
        resid = ssub(sumsq_y, expl);
        var_v = 0;
        rsq = 0;
        if (resid > 0) var_v = scaled_quot(resid, 64'sd4096, 64'(n));
        if (sumsq_y > 0) begin
          rsq = scaled_quot(expl, ONE_Q32, sumsq_y);
          if (rsq < 0) rsq = 0;
          if (rsq > ONE_Q32) rsq = ONE_Q32;
        end
        if (var_v <= 0 || sumsq_y <= 0) begin
          r.status = STAT_RESID;
          if (var_v < 0) var_v = 0;
        end else begin
          term = ONE_Q32 + ln_fixed(TWO_PI_Q32) + ln_fixed(var_v);
          r.log_likelihood = -((longint'(n) * term) / 2);
        end
        r.residual_variance = var_v[62:0];
        r.r_squared = rsq[32:0];
      end
      r.prefix_count = n[15:0];
      r.last_result = (n + mc == len);
      fit_q.push_back(r);
    end
    if (n >= len) clear_fit_state();
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // result checker and receiver stall pattern
  int stall_phase;
  always @(posedge clk) begin
    olr_res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 600;
      if (stall_phase < 200) out_ready <= 1'b1;
      else if (stall_phase < 400) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 3) == 0);
      if (out_valid && out_ready) begin
        if (fit_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_prefix_count, 0);
        end else begin
          e = fit_q.pop_front();
          fits_checked++;
          if (e.status < 3) status_seen[e.status]++;
          if (out_slope !== e.slope) report_mismatch("slope", out_slope, e.slope);
          if (out_intercept !== e.intercept)
            report_mismatch("intercept", out_intercept, e.intercept);
          if (out_residual_variance !== e.residual_variance)
            report_mismatch("residual_variance", out_residual_variance,
                            e.residual_variance);
          if (out_r_squared !== e.r_squared)
            report_mismatch("r_squared", out_r_squared, e.r_squared);
          if (out_log_likelihood !== e.log_likelihood)
            report_mismatch("log_likelihood", out_log_likelihood, e.log_likelihood);
          if (out_prefix_count !== e.prefix_count)
            report_mismatch("prefix_count", out_prefix_count, e.prefix_count);
          if (out_status !== e.status) report_mismatch("status", out_status, e.status);
          if (out_last_result !== e.last_result)
            report_mismatch("last_result", out_last_result, e.last_result);
        end
      end
    end
  end

  // one input transaction, valid held across a burst
  task automatic send_sample(logic signed [31:0] sx, logic signed [31:0] sy);
    in_valid <= 1'b1;
    in_sample_x <= sx;
    in_sample_y <= sy;
    do @(posedge clk); while (!in_ready);
    predict_fit(sx, sy);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  // sender pauses until every expected result has come, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_CLUSTER) min_cluster_reg = val & 16'h7FFF;
    else series_len_reg = val;
  endtask

  task automatic configure(int unsigned mc, int unsigned len);
    drain();
    write_reg(CFG_MIN_CLUSTER, mc[15:0]);
    write_reg(CFG_SERIES_LEN, len[15:0]);
  endtask

  task automatic test_reset_defaults();
    logic signed [31:0] xs[12], ys[12];
    xs = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh0001_0000,
           32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0002_0000, -5, 32'sh4000_0000, 3};
    ys = '{32'sh8000_0000, 32'sh7FFF_FFFF, -1, 0, 32'sh7FFF_FFFF, 32'sh0003_0000,
           32'sh8000_0000, 1, 32'shFFFF_0000, 7, 32'shC000_0000, -3};
    foreach (xs[i]) send_sample(xs[i], ys[i]);
    // shortest length clears the long default series
    configure(10, 0);
    send_sample(5, 5);
  endtask

  task automatic test_zero_x_variance();
    configure(0, 4);
    for (int i = 0; i < 4; i++) send_sample(32'sh0005_0000, $urandom_range(0, 32'hFFFF) << i);
  endtask

  task automatic test_flat_residual();
    configure(2, 5);
    for (int i = 0; i < 5; i++) send_sample(i * 32'sh0001_0000, i * 32'sh0003_0000);
    configure(1, 3);
    for (int i = 0; i < 3; i++) send_sample(i * 32'sh0001_0000, 32'sh0002_0000);
  endtask

  task automatic test_register_extremes();
    configure(16'hFFFF, 16'hFFFF);
    send_sample(32'sh0001_0000, 32'sh0002_0000);
    send_sample(32'sh0003_0000, 32'sh0001_0000);
    // the mid-series change shortens the cluster so the same series emits
    drain();
    write_reg(CFG_MIN_CLUSTER, 1);
    send_sample(32'sh0002_0000, 32'sh0005_0000);
    send_sample(-32'sh0001_0000, 32'sh0004_0000);
    drain();
    write_reg(CFG_SERIES_LEN, 2);
    send_sample(7, 9);
  endtask

  function automatic logic signed [31:0] pick_value(int unsigned mode, logic signed [31:0] base);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
      2: return base * 3 + $signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000;
      default: return base;
    endcase
  endfunction

  task automatic test_random_series();
    int unsigned mc, len, count, mode;
    logic signed [31:0] sx, sy;
    while (samples_sent < 650) begin
      mc = $urandom_range(1, 4);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 2 * mc) :
                                         $urandom_range(2 * mc, 2 * mc + 8);
      configure(mc, len);
      mode = $urandom_range(0, 4);
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
      sx = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      for (int i = 0; i < count; i++) begin
        if (mode != 4) sx = pick_value(mode == 3 ? 1 : mode, sx);
        sy = (mode == 2) ? pick_value(2, sx) : pick_value(mode == 4 ? 0 : mode % 2, sx);
        send_sample(sx, sy);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_x = '0;
    in_sample_y = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_CLUSTER;
    cfg_wdata = '0;
    cycle_count = 0;
    error_count = 0;
    samples_sent = 0;
    fits_checked = 0;
    status_seen = '{0, 0, 0};
    burst_left = 0;
    min_cluster_reg = 10;
    series_len_reg = 1024;
    clear_fit_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_x_variance();
    test_flat_residual();
    test_register_extremes();
    test_random_series();
    drain();

    $display("sent %0d samples, checked %0d fit results", samples_sent, fits_checked);
    $display("status mix ok/zero-x-variance/residual: %0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2]);
    if (error_count == 0 && fit_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
